>>> rtl/max_sum_submatrix_search_assert.svh
// Assertion macros used by the RTL of the maximum sum submatrix search.
`ifndef MAX_SUM_SUBMATRIX_SEARCH_ASSERT_SVH
`define MAX_SUM_SUBMATRIX_SEARCH_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Clocked check, disabled while the active-low reset is asserted.
`define MSS_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define MSS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define MSS_ASSERT(label, clk, rst_n, prop, msg)
`define MSS_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

>>> rtl/mss_pkg.sv
// Package of the maximum sum submatrix search: widths, register indexes and sequencer states.
package mss_pkg;

  localparam int unsigned ElemWidth   = 16;
  localparam int unsigned SumOutWidth = 24;
  localparam int unsigned IdxOutWidth = 4;
  localparam int unsigned CfgIdxWidth = 2;
  localparam int unsigned CfgDatWidth = 5;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1
  } reg_index_e;

  typedef enum logic [3:0] {
    ST_LOAD   = 4'b0001,
    ST_SEARCH = 4'b0010,
    ST_DRAIN  = 4'b0100,
    ST_RESULT = 4'b1000
  } state_e;

endpackage

>>> rtl/max_sum_submatrix_search.sv
// Top level of the maximum sum submatrix search: loader, prefix-sum memory and search sequencer.
//
// The block takes a signed matrix one element per word, in row-major order, while busy_o is low;
// the matrix size comes from the row and column count registers, written through the
// configuration channel (a zero counts as one, a value above the maximum counts as the maximum,
// and any write to either register discards a partly loaded matrix). Each element is taken in
// a single cycle and turned at once into a running row prefix sum held in an internal memory.
// When the last element arrives busy_o rises and the search runs over every rectangle, one
// rectangle per clock cycle, through a single subtract, accumulate and compare path fed by the
// two read ports of the prefix-sum memory. The search covers cols*(cols+1)/2 * rows*(rows+1)/2
// rectangles, followed by the drain of the pipeline and the result hand-over. The result word
// (corners and sum, the sum saturated to 24 bits) is shown for exactly one cycle with done_o
// high, and busy_o falls in the following cycle. The receiver cannot stall the result: it must
// take it in that cycle. Among rectangles of equal sum the first in the order left column, top
// row, right column, bottom row is reported.
module max_sum_submatrix_search #(
  parameter int unsigned MAX_ROWS = 16,
  parameter int unsigned MAX_COLS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // element channel
  input  logic                                start_i,
  output logic                                busy_o,
  input  logic signed [mss_pkg::ElemWidth-1:0] element_value_i,
  // configuration channel
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [mss_pkg::CfgIdxWidth-1:0]     cfg_index_i,
  input  logic [mss_pkg::CfgDatWidth-1:0]     cfg_data_i,
  // result channel
  output logic                                done_o,
  output logic [mss_pkg::IdxOutWidth-1:0]     left_col_o,
  output logic [mss_pkg::IdxOutWidth-1:0]     top_row_o,
  output logic [mss_pkg::IdxOutWidth-1:0]     right_col_o,
  output logic [mss_pkg::IdxOutWidth-1:0]     bottom_row_o,
  output logic signed [mss_pkg::SumOutWidth-1:0] best_sum_o
);
  import mss_pkg::*;

`include "max_sum_submatrix_search_assert.svh"

  // Widths that follow from the matrix limits.
  localparam int unsigned Depth = MAX_ROWS * MAX_COLS;
  localparam int unsigned AW    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned RW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned NRW   = $clog2(MAX_ROWS + 1);
  localparam int unsigned NCW   = $clog2(MAX_COLS + 1);
  // A row prefix sum covers at most MAX_COLS elements, a rectangle at most Depth elements.
  localparam int unsigned PW    = ElemWidth + $clog2(MAX_COLS);
  localparam int unsigned SW    = ElemWidth + $clog2(Depth);
  localparam int unsigned XW    = (SW > SumOutWidth) ? SW : SumOutWidth;

  localparam logic [7:0] MaxRows8 = 8'(MAX_ROWS);
  localparam logic [7:0] MaxCols8 = 8'(MAX_COLS);
  localparam logic signed [XW-1:0] SatMax = XW'(24'sh7FFFFF);
  localparam logic signed [XW-1:0] SatMin = XW'(24'sh800000);

  // Indices of one rectangle travelling down the search pipeline.
  typedef struct packed {
    logic          first;   // bottom row equals top row: restart the running sum
    logic          hzero;   // left column is column zero: no prefix to subtract
    logic [CW-1:0] h;
    logic [RW-1:0] i;
    logic [CW-1:0] j;
    logic [RW-1:0] k;
  } tag_t;

  // ---------------------------------------------------------------------------------------------
  // Configuration registers and effective matrix size
  // ---------------------------------------------------------------------------------------------
  logic [CfgDatWidth-1:0] row_count_q, col_count_q;
  logic [7:0]             rows8, cols8;
  logic [NRW-1:0]         rows_eff;
  logic [NCW-1:0]         cols_eff;
  logic                   cfg_we, cfg_hit;

  state_e state_q, state_d;

  assign cfg_ready_o = (state_q == ST_LOAD);
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign cfg_hit     = cfg_we && ((cfg_index_i == REG_ROW_COUNT) ||
                                  (cfg_index_i == REG_COL_COUNT));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q <= CfgDatWidth'(1);
      col_count_q <= CfgDatWidth'(1);
    end else if (cfg_we) begin
      case (cfg_index_i)
        REG_ROW_COUNT: row_count_q <= cfg_data_i;
        REG_COL_COUNT: col_count_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // A zero counts as one, anything above the limit counts as the limit.
  always_comb begin
    rows8 = 8'(row_count_q);
    cols8 = 8'(col_count_q);
    if (rows8 == 8'd0) begin
      rows8 = 8'd1;
    end else if (rows8 > MaxRows8) begin
      rows8 = MaxRows8;
    end
    if (cols8 == 8'd0) begin
      cols8 = 8'd1;
    end else if (cols8 > MaxCols8) begin
      cols8 = MaxCols8;
    end
    rows_eff = rows8[NRW-1:0];
    cols_eff = cols8[NCW-1:0];
  end

  // ---------------------------------------------------------------------------------------------
  // Loader: row prefix sums are formed as the elements arrive
  // ---------------------------------------------------------------------------------------------
  logic                 in_we;
  logic [AW-1:0]        ld_addr_q;
  logic [RW-1:0]        ld_row_q;
  logic [CW-1:0]        ld_col_q;
  logic signed [PW-1:0] run_q, run_d;
  logic                 ld_last_col, ld_last_row, ld_last;

  assign busy_o      = (state_q != ST_LOAD);
  assign in_we       = start_i && !busy_o;
  assign ld_last_col = (NCW'(ld_col_q) + NCW'(1)) == cols_eff;
  assign ld_last_row = (NRW'(ld_row_q) + NRW'(1)) == rows_eff;
  assign ld_last     = ld_last_col && ld_last_row;

  always_comb begin
    if (ld_col_q == '0) begin
      run_d = PW'(element_value_i);
    end else begin
      run_d = run_q + PW'(element_value_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_we) begin
      run_q <= run_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ld_addr_q <= '0;
      ld_row_q  <= '0;
      ld_col_q  <= '0;
    end else if (cfg_hit || (in_we && ld_last)) begin
      ld_addr_q <= '0;
      ld_row_q  <= '0;
      ld_col_q  <= '0;
    end else if (in_we) begin
      ld_addr_q <= ld_addr_q + AW'(1);
      if (ld_last_col) begin
        ld_col_q <= '0;
        ld_row_q <= ld_row_q + RW'(1);
      end else begin
        ld_col_q <= ld_col_q + CW'(1);
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Search sequencer: issues one rectangle per cycle
  // ---------------------------------------------------------------------------------------------
  logic [CW-1:0] h_q, h_d, j_q, j_d;
  logic [RW-1:0] i_q, i_d, k_q, k_d;
  logic [AW-1:0] ib_q, ib_d, kb_q, kb_d;   // base addresses of rows i and k
  logic          last_h, last_i, last_j, last_k;
  logic          issue, search_end;
  logic          p1_v_q, p2_v_q, p3_v_q;
  tag_t          p1_q, p2_q, p3_q;
  tag_t          tag_now;

  assign issue  = (state_q == ST_SEARCH);
  assign last_k = (NRW'(k_q) + NRW'(1)) == rows_eff;
  assign last_i = (NRW'(i_q) + NRW'(1)) == rows_eff;
  assign last_j = (NCW'(j_q) + NCW'(1)) == cols_eff;
  assign last_h = (NCW'(h_q) + NCW'(1)) == cols_eff;
  assign search_end = last_k && last_j && last_i && last_h;

  always_comb begin
    h_d  = h_q;
    i_d  = i_q;
    j_d  = j_q;
    k_d  = k_q;
    ib_d = ib_q;
    kb_d = kb_q;
    if (in_we && ld_last) begin
      h_d  = '0;
      i_d  = '0;
      j_d  = '0;
      k_d  = '0;
      ib_d = '0;
      kb_d = '0;
    end else if (issue) begin
      if (!last_k) begin
        k_d  = k_q + RW'(1);
        kb_d = kb_q + AW'(cols_eff);
      end else if (!last_j) begin
        j_d  = j_q + CW'(1);
        k_d  = i_q;
        kb_d = ib_q;
      end else if (!last_i) begin
        i_d  = i_q + RW'(1);
        ib_d = ib_q + AW'(cols_eff);
        j_d  = h_q;
        k_d  = i_q + RW'(1);
        kb_d = ib_q + AW'(cols_eff);
      end else if (!last_h) begin
        h_d  = h_q + CW'(1);
        j_d  = h_q + CW'(1);
        i_d  = '0;
        k_d  = '0;
        ib_d = '0;
        kb_d = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q  <= '0;
      i_q  <= '0;
      j_q  <= '0;
      k_q  <= '0;
      ib_q <= '0;
      kb_q <= '0;
    end else begin
      h_q  <= h_d;
      i_q  <= i_d;
      j_q  <= j_d;
      k_q  <= k_d;
      ib_q <= ib_d;
      kb_q <= kb_d;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Prefix-sum memory: one write port for the loader, two registered read ports for the search.
  // Entry r*cols+c holds the sum of row r, columns 0 to c.
  // ---------------------------------------------------------------------------------------------
  logic signed [PW-1:0] pre_mem [Depth];
  logic signed [PW-1:0] rd_a_q, rd_b_q;
  logic [AW-1:0]        addr_a, addr_b;

  assign addr_a = kb_q + AW'(j_q);
  assign addr_b = kb_q + AW'(h_q) - AW'(1);

  always_ff @(posedge clk_i) begin
    if (in_we) begin
      pre_mem[ld_addr_q] <= run_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_a_q <= pre_mem[addr_a];
    rd_b_q <= pre_mem[addr_b];
  end

  // ---------------------------------------------------------------------------------------------
  // Datapath: segment sum, running rectangle sum, compare against the best so far
  // ---------------------------------------------------------------------------------------------
  logic signed [PW-1:0] diff_q;
  logic signed [SW-1:0] s_q, best_q;
  logic                 have_q;
  logic [CW-1:0]        best_h_q, best_j_q;
  logic [RW-1:0]        best_i_q, best_k_q;

  always_comb begin
    tag_now.first = (k_q == i_q);
    tag_now.hzero = (h_q == '0);
    tag_now.h     = h_q;
    tag_now.i     = i_q;
    tag_now.j     = j_q;
    tag_now.k     = k_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_q <= tag_now;
    p2_q <= p1_q;
    p3_q <= p2_q;
    // Sum of row k over columns h to j; fits the prefix width, so wrap-around is harmless.
    diff_q <= p1_q.hzero ? rd_a_q : (rd_a_q - rd_b_q);
    if (p2_v_q) begin
      if (p2_q.first) begin
        s_q <= SW'(diff_q);
      end else begin
        s_q <= s_q + SW'(diff_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q <= 1'b0;
    end else if (in_we && ld_last) begin
      have_q <= 1'b0;
    end else if (p3_v_q) begin
      have_q <= 1'b1;
    end
  end

  // Strictly greater only, so the earliest rectangle keeps a tie.
  always_ff @(posedge clk_i) begin
    if (p3_v_q && (!have_q || (s_q > best_q))) begin
      best_q   <= s_q;
      best_h_q <= p3_q.h;
      best_i_q <= p3_q.i;
      best_j_q <= p3_q.j;
      best_k_q <= p3_q.k;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // Control state and result register
  // ---------------------------------------------------------------------------------------------
  logic                  pipe_empty;
  logic signed [XW-1:0]  best_x, best_sat;

  assign pipe_empty = !p1_v_q && !p2_v_q && !p3_v_q;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_LOAD:   if (in_we && ld_last) state_d = ST_SEARCH;
      ST_SEARCH: if (search_end) state_d = ST_DRAIN;
      ST_DRAIN:  if (pipe_empty) state_d = ST_RESULT;
      ST_RESULT: state_d = ST_LOAD;
      default:   state_d = ST_LOAD;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    best_x = XW'(best_q);
    if (best_x > SatMax) begin
      best_sat = SatMax;
    end else if (best_x < SatMin) begin
      best_sat = SatMin;
    end else begin
      best_sat = best_x;
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == ST_DRAIN) && pipe_empty) begin
      left_col_o   <= IdxOutWidth'(best_h_q);
      top_row_o    <= IdxOutWidth'(best_i_q);
      right_col_o  <= IdxOutWidth'(best_j_q);
      bottom_row_o <= IdxOutWidth'(best_k_q);
      best_sum_o   <= best_sat[SumOutWidth-1:0];
    end
  end

  assign done_o = (state_q == ST_RESULT);

  // ---------------------------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------------------------
  `MSS_ASSERT(a_done_pipe_empty, clk_i, rst_ni, done_o |-> pipe_empty && have_q,
              "result given before the search pipeline drained")
  `MSS_ASSERT(a_done_single, clk_i, rst_ni, done_o |=> !done_o && !busy_o,
              "result strobe longer than one cycle")
  `MSS_ASSERT(a_bottom_below_top, clk_i, rst_ni, issue |-> (k_q >= i_q) && (j_q >= h_q),
              "rectangle issued with inverted corners")
  `MSS_ASSERT(a_no_load_while_busy, clk_i, rst_ni, busy_o |=> $stable(ld_addr_q),
              "loader advanced during a search")

endmodule
